[rtl/core/fmmc_pkg.sv]
// ----------------------------------------------------------------------------
// fmmc_pkg
// Shared types, codes and reset values for the freeze/melt mode controller.
// ----------------------------------------------------------------------------
package fmmc_pkg;

	// control modes
	localparam logic [1:0] MODE_HOLD     = 2'd0;
	localparam logic [1:0] MODE_MANUAL   = 2'd1;
	localparam logic [1:0] MODE_SPEED    = 2'd2;
	localparam logic [1:0] MODE_DISTANCE = 2'd3;

	// configuration register indexes
	localparam int          CFG_INDEX_W        = 3;
	localparam logic [2:0] REG_CONTROL_MODE   = 3'd0;
	localparam logic [2:0] REG_MANUAL_MELT    = 3'd1;
	localparam logic [2:0] REG_FAN_ENABLE     = 3'd2;
	localparam logic [2:0] REG_FIXATION_TICKS = 3'd3;
	localparam logic [2:0] REG_SPEED_LIMIT    = 3'd4;
	localparam logic [2:0] REG_DISTANCE_LIMIT = 3'd5;

	localparam int CFG_DATA_W  = 12;
	localparam int FIX_W       = 9;
	localparam int SPEED_LIM_W = 11;
	localparam int DIST_LIM_W  = 12;
	localparam int SAMPLE_W    = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 8;

	localparam int COUNT_BITS_DEF = 16;

	// pulse pattern period
	localparam logic [2:0] PULSE_LAST = 3'd4;

	localparam logic [1:0]             RST_CONTROL_MODE   = MODE_SPEED;
	localparam logic                   RST_MANUAL_MELT    = 1'b1;
	localparam logic                   RST_FAN_ENABLE     = 1'b1;
	localparam logic [FIX_W-1:0]       RST_FIXATION_TICKS = 9'd500;
	localparam logic [SPEED_LIM_W-1:0] RST_SPEED_LIMIT    = 11'd512;
	localparam logic [DIST_LIM_W-1:0]  RST_DISTANCE_LIMIT = 12'd3200;

	// control to one phase counter
	typedef struct packed {
		logic step;    // timed-mode transaction advancing the counters
		logic active;  // phase flag before this tick
	} phase_ctl_t;

endpackage

[rtl/core/fmmc_phase_ctr.sv]
// ----------------------------------------------------------------------------
// fmmc_phase_ctr
// Saturating phase tick counter with a modulo-5 pulse phase; both advance on a step and clear on a step while inactive.
// ----------------------------------------------------------------------------
module fmmc_phase_ctr #(
	parameter int COUNT_BITS = fmmc_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fmmc_pkg::phase_ctl_t            ctl,
	input  logic [fmmc_pkg::FIX_W-1:0]      fixation_ticks,
	output logic                            pulse
);
	import fmmc_pkg::*;

	logic [COUNT_BITS-1:0] ticks_q, ticks_nxt;
	logic [2:0]            mod5_q, mod5_nxt;

	always_comb begin
		if (!ctl.active) begin
			ticks_nxt = '0;
			mod5_nxt  = '0;
		end else begin
			ticks_nxt = (&ticks_q) ? ticks_q : ticks_q + 1'b1;
			mod5_nxt  = (mod5_q >= PULSE_LAST) ? 3'd0 : mod5_q + 3'd1;
		end
	end

	assign pulse = ctl.active
		&& (ticks_nxt > COUNT_BITS'(fixation_ticks))
		&& (mod5_nxt == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			mod5_q  <= '0;
		end else if (ctl.step) begin
			ticks_q <= ticks_nxt;
			mod5_q  <= mod5_nxt;
		end
	end

endmodule

[rtl/core/freeze_melt_mode_controller.sv]
// ----------------------------------------------------------------------------
// freeze_melt_mode_controller
// Per-tick fan and freeze command from speed or distance samples.
// ----------------------------------------------------------------------------
// Path: an input transaction passes the input register, then the phase
//   update and result register.
// Throughput: one transaction per cycle while m_tready does not stall the
//   output; the phase and counter update feeds the next tick.
// Reset: arst_n clears phase flags, counters, command and pipeline valids;
//   configuration returns to speed mode, melt, fan on, 500, 512, 3200.
module freeze_melt_mode_controller #(
	parameter int COUNT_BITS = fmmc_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [fmmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fmmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [15:0] speed_sample, [31:16] distance_sample
	input  logic [fmmc_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] fan_on, [1] freeze_cmd, [7:2] zero
	output logic [fmmc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import fmmc_pkg::*;

	// configuration
	logic [1:0]             control_mode_q;
	logic                   manual_melt_q;
	logic                   fan_enable_q;
	logic [FIX_W-1:0]       fixation_ticks_q;
	logic [SPEED_LIM_W-1:0] speed_limit_q;
	logic [DIST_LIM_W-1:0]  distance_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q   <= RST_CONTROL_MODE;
			manual_melt_q    <= RST_MANUAL_MELT;
			fan_enable_q     <= RST_FAN_ENABLE;
			fixation_ticks_q <= RST_FIXATION_TICKS;
			speed_limit_q    <= RST_SPEED_LIMIT;
			distance_limit_q <= RST_DISTANCE_LIMIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CONTROL_MODE:   control_mode_q   <= cfg_data[1:0];
				REG_MANUAL_MELT:    manual_melt_q    <= cfg_data[0];
				REG_FAN_ENABLE:     fan_enable_q     <= cfg_data[0];
				REG_FIXATION_TICKS: fixation_ticks_q <= cfg_data[FIX_W-1:0];
				REG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[SPEED_LIM_W-1:0];
				REG_DISTANCE_LIMIT: distance_limit_q <= cfg_data[DIST_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                valid_s1;
	logic [SAMPLE_W-1:0] speed_s1, dist_s1;
	logic                out_free, advance;

	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			speed_s1 <= s_tdata[SAMPLE_W-1:0];
			dist_s1  <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	// phase update
	logic       freezing_q, melting_q, command_q;
	logic       timed, manual, melt_next, freeze_pulse, melt_pulse, command_nxt;
	phase_ctl_t freeze_ctl, melt_ctl;

	assign timed  = (control_mode_q == MODE_SPEED) || (control_mode_q == MODE_DISTANCE);
	assign manual = (control_mode_q == MODE_MANUAL);

	assign freeze_ctl = '{step: advance && timed, active: freezing_q};
	assign melt_ctl   = '{step: advance && timed, active: melting_q};

	fmmc_phase_ctr #(.COUNT_BITS(COUNT_BITS)) u_freeze_ctr (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (freeze_ctl),
		.fixation_ticks (fixation_ticks_q),
		.pulse          (freeze_pulse)
	);

	fmmc_phase_ctr #(.COUNT_BITS(COUNT_BITS)) u_melt_ctr (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (melt_ctl),
		.fixation_ticks (fixation_ticks_q),
		.pulse          (melt_pulse)
	);

	assign melt_next = (control_mode_q == MODE_SPEED)
		? (speed_s1 > SAMPLE_W'(speed_limit_q))
		: (dist_s1 < SAMPLE_W'(distance_limit_q));

	always_comb begin
		command_nxt = command_q;
		if (manual) begin
			command_nxt = !manual_melt_q;
		end else if (timed) begin
			if (freeze_pulse)    command_nxt = 1'b0;
			else if (freezing_q) command_nxt = 1'b1;
			// melting phase applied second, as it overrides
			if (melt_pulse)      command_nxt = 1'b1;
			else if (melting_q)  command_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freezing_q <= 1'b0;
			melting_q  <= 1'b0;
			command_q  <= 1'b0;
		end else if (advance) begin
			command_q <= command_nxt;
			if (manual) begin
				freezing_q <= 1'b0;
				melting_q  <= 1'b0;
			end else if (timed) begin
				freezing_q <= !melt_next;
				melting_q  <= melt_next;
			end
		end
	end

	// result register
	logic fan_s2, cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fan_s2 <= fan_enable_q;
			cmd_s2 <= command_nxt;
		end
	end

	assign m_tdata = {6'd0, cmd_s2, fan_s2};

	// checks
	a_timed_flags_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && timed) |=> (freezing_q != melting_q))
		else $error("phase flags not opposite after timed tick");

	a_manual_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && manual) |=> (!freezing_q && !melting_q))
		else $error("manual tick left a phase flag set");

	a_hold_keeps_command: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && control_mode_q == MODE_HOLD) |=> $stable(command_q))
		else $error("command changed in hold mode");

	a_result_matches_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (cmd_s2 == command_q))
		else $error("result command differs from state");

endmodule

[tb/tb_freeze_melt_mode_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_freeze_melt_mode_controller
// Self-checking bench for the freeze/melt mode controller: a scoreboard model
// tracks phase flags, saturating tick counts and the one-in-five pulse, and
// every output transaction is checked against it. Stimulus is directed
// tests (reset settings, manual, hold, distance, zero speed threshold),
// a freezing and a melting run past a short fixation time, then randomised
// phase runs under changing settings, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_freeze_melt_mode_controller;
	import fmmc_pkg::*;

	localparam int FRZ = 0;
	localparam int MLT = 1;

	typedef struct packed {
		logic freeze_cmd;
		logic fan_on;
	} tick_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// settings as the block sees them
	logic [1:0] cur_mode = RST_CONTROL_MODE;
	logic cur_melt = RST_MANUAL_MELT;
	logic cur_fan = RST_FAN_ENABLE;
	logic [FIX_W-1:0] cur_fix = RST_FIXATION_TICKS;
	logic [SPEED_LIM_W-1:0] cur_slim = RST_SPEED_LIMIT;
	logic [DIST_LIM_W-1:0] cur_dlim = RST_DISTANCE_LIMIT;

	// controller state
	bit phase_on[2];
	logic [COUNT_BITS_DEF-1:0] phase_ticks[2];
	logic [2:0] phase_mod5[2];
	logic held_cmd;

	logic [IN_TDATA_W-1:0] pending_ticks[$];
	tick_result_t expected_results[$];
	tick_result_t want;
	int fault_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	freeze_melt_mode_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// one phase counter; true on a pulse tick
	function automatic bit advance_count(int p);
		if (!phase_on[p]) begin
			phase_ticks[p] = '0;
			phase_mod5[p] = '0;
			return 1'b0;
		end
		if (phase_ticks[p] != '1)
			phase_ticks[p] = phase_ticks[p] + 1'b1;
		phase_mod5[p] = (phase_mod5[p] >= PULSE_LAST) ? 3'd0 : phase_mod5[p] + 3'd1;
		return (phase_ticks[p] > cur_fix) && (phase_mod5[p] == 3'd0);
	endfunction

	function automatic tick_result_t control_tick(logic [15:0] spd, logic [15:0] dst);
		tick_result_t res;
		bit melt_next;
		if (cur_mode == MODE_MANUAL) begin
			phase_on[FRZ] = 1'b0;
			phase_on[MLT] = 1'b0;
			held_cmd = !cur_melt;
		end else if (cur_mode == MODE_SPEED || cur_mode == MODE_DISTANCE) begin
			if (advance_count(FRZ))
				held_cmd = 1'b0;
			else if (phase_on[FRZ])
				held_cmd = 1'b1;
			if (advance_count(MLT))
				held_cmd = 1'b1;
			else if (phase_on[MLT])
				held_cmd = 1'b0;
			melt_next = (cur_mode == MODE_SPEED) ? (spd > cur_slim) : (dst < cur_dlim);
			phase_on[MLT] = melt_next;
			phase_on[FRZ] = !melt_next;
		end
		res.fan_on = cur_fan;
		res.freeze_cmd = held_cmd;
		return res;
	endfunction

	// sample pair that steers the next phase to melt or freeze
	function automatic logic [IN_TDATA_W-1:0] tick_item(bit melt);
		logic [15:0] spd;
		logic [15:0] dst;
		bit edge_hit;
		spd = 16'($urandom);
		dst = 16'($urandom);
		edge_hit = ($urandom_range(7) == 0);
		if (cur_mode == MODE_SPEED) begin
			if (melt)
				spd = edge_hit ? 16'(int'(cur_slim) + 1)
					: 16'($urandom_range(65535, int'(cur_slim) + 1));
			else
				spd = edge_hit ? 16'(cur_slim) : 16'($urandom_range(int'(cur_slim), 0));
		end else if (cur_mode == MODE_DISTANCE) begin
			if (melt && cur_dlim != '0)
				dst = edge_hit ? 16'(int'(cur_dlim) - 1)
					: 16'($urandom_range(int'(cur_dlim) - 1, 0));
			else
				dst = edge_hit ? 16'(cur_dlim) : 16'($urandom_range(65535, int'(cur_dlim)));
		end
		return {dst, spd};
	endfunction

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_CONTROL_MODE:   cur_mode = val[1:0];
			REG_MANUAL_MELT:    cur_melt = val[0];
			REG_FAN_ENABLE:     cur_fan = val[0];
			REG_FIXATION_TICKS: cur_fix = val[FIX_W-1:0];
			REG_SPEED_LIMIT:    cur_slim = val[SPEED_LIM_W-1:0];
			REG_DISTANCE_LIMIT: cur_dlim = val[DIST_LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [1:0] mode, int unsigned melt, int unsigned fan,
			int unsigned fix, int unsigned slim, int unsigned dlim);
		cfg_write(REG_CONTROL_MODE, mode);
		cfg_write(REG_MANUAL_MELT, melt);
		cfg_write(REG_FAN_ENABLE, fan);
		cfg_write(REG_FIXATION_TICKS, fix);
		cfg_write(REG_SPEED_LIMIT, slim);
		cfg_write(REG_DISTANCE_LIMIT, dlim);
	endtask

	// wait for the pipeline to empty
	task automatic drain();
		while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// runs of same-phase samples with random content, plus some noise
	task automatic queue_runs(int n);
		int queued;
		int len;
		int r;
		bit melt;
		queued = 0;
		while (queued < n) begin
			r = $urandom_range(99);
			melt = 1'($urandom_range(1));
			if (r < 12) begin
				pending_ticks.push_back($urandom);
				queued++;
			end else begin
				if (r < 80)
					len = $urandom_range(8, 1);
				else if (r < 97)
					len = $urandom_range(60, 9);
				else
					len = $urandom_range(560, 300);
				if (len > n - queued)
					len = n - queued;
				repeat (len) pending_ticks.push_back(tick_item(melt));
				queued += len;
			end
		end
	endtask

	// driver: prediction is taken at the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(control_tick(s_tdata[15:0], s_tdata[31:16]));
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_ticks.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_fault($sformatf("result %02h with nothing outstanding", m_tdata));
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[0] !== want.fan_on)
						report_fault($sformatf("fan_on exp %0b got %0b", want.fan_on, m_tdata[0]));
					if (m_tdata[1] !== want.freeze_cmd)
						report_fault($sformatf("freeze_cmd exp %0b got %0b",
							want.freeze_cmd, m_tdata[1]));
				end
			end
		end
	end

	initial begin
		phase_on[FRZ] = 1'b0;
		phase_on[MLT] = 1'b0;
		phase_ticks[FRZ] = '0;
		phase_ticks[MLT] = '0;
		phase_mod5[FRZ] = '0;
		phase_mod5[MLT] = '0;
		held_cmd = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// settings straight out of reset, samples around the speed threshold
		pending_ticks.push_back({16'd0, 16'd513});
		pending_ticks.push_back({16'd65535, 16'd512});
		pending_ticks.push_back({16'd3199, 16'd0});
		pending_ticks.push_back({16'd0, 16'd65535});
		pending_ticks.push_back({16'hAAAA, 16'd511});
		drain();

		// manual freeze then melt, then hold
		program_all(MODE_MANUAL, 0, 0, 0, 2047, 4095);
		pending_ticks.push_back({16'd65535, 16'd65535});
		pending_ticks.push_back({16'd0, 16'd0});
		drain();
		cfg_write(REG_MANUAL_MELT, 1);
		pending_ticks.push_back({16'h5555, 16'hAAAA});
		drain();
		cfg_write(REG_CONTROL_MODE, MODE_HOLD);
		pending_ticks.push_back({16'd0, 16'd65535});
		pending_ticks.push_back({16'd65535, 16'd0});
		drain();

		// distance mode at the top limit, zero fixation so no fixation time delays the pulse
		cfg_write(REG_CONTROL_MODE, MODE_DISTANCE);
		pending_ticks.push_back({16'd4095, 16'd0});
		pending_ticks.push_back({16'd65535, 16'd0});
		repeat (7) pending_ticks.push_back({16'd4094, 16'd65535});
		pending_ticks.push_back({16'd0, 16'd0});
		drain();

		// speed mode with a zero threshold
		program_all(MODE_SPEED, 0, 1, 0, 0, 0);
		pending_ticks.push_back({16'd0, 16'd0});
		pending_ticks.push_back({16'd0, 16'd1});
		pending_ticks.push_back({16'd65535, 16'd1});
		pending_ticks.push_back({16'd0, 16'd0});
		drain();

		// freezing then melting run past a short fixation time
		program_all(MODE_SPEED, 1, 1, 3, 2047, 4095);
		repeat (20) pending_ticks.push_back(tick_item(1'b0));
		drain();
		cfg_write(REG_CONTROL_MODE, MODE_DISTANCE);
		repeat (20) pending_ticks.push_back(tick_item(1'b1));
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			logic [1:0] mode;
			int unsigned fix;
			int unsigned slim;
			int unsigned dlim;
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			case ($urandom_range(9))
				0: mode = MODE_HOLD;
				1: mode = MODE_MANUAL;
				2, 3, 4, 5: mode = MODE_SPEED;
				default: mode = MODE_DISTANCE;
			endcase
			case ($urandom_range(5))
				0: fix = 0;
				1: fix = $urandom_range(3, 1);
				2: fix = $urandom_range(20, 4);
				3: fix = 500;
				4: fix = 511;
				default: fix = $urandom_range(511);
			endcase
			case ($urandom_range(3))
				0: slim = 0;
				1: slim = 1280;
				2: slim = 2047;
				default: slim = $urandom_range(2047);
			endcase
			case ($urandom_range(3))
				0: dlim = 0;
				1: dlim = 3200;
				2: dlim = 4095;
				default: dlim = $urandom_range(4095);
			endcase
			// first two phases pin the extremes
			if (ph == 0) begin
				fix = 0;
				slim = 0;
				dlim = 0;
			end else if (ph == 1) begin
				fix = 511;
				slim = 2047;
				dlim = 4095;
			end
			program_all(mode, $urandom_range(1), $urandom_range(1), fix, slim, dlim);
			queue_runs(70);
			drain();
		end

		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
